// File: rtl/tcbac_pkg.sv
// tcbac_pkg: shared types, constants and calibration table for the
// temperature-compensated BAC lookup. No dependencies.
package tcbac_pkg;

   // Field widths
   localparam int GasW   = 10;
   localparam int TempW  = 10;
   localparam int ShiftW = 8;
   localparam int AdjW   = 12;
   localparam int BacW   = 8;
   localparam int ProdW  = GasW + ShiftW;      // full-width gas * gain

   // Shared divider widths
   localparam int DivDW  = ProdW;              // dividend / quotient
   localparam int DivVW  = AdjW;               // divisor / remainder
   localparam int DivCntW = $clog2(DivDW + 1);

   // Arithmetic constants
   localparam int PctDiv  = 100;
   localparam int SegStep = 10;
   localparam int BacMax  = 255;
   localparam int BacSumW = DivDW + 1;

   // Divide by 100 as a reciprocal multiply: (x * RecipPct) >> RecipShift
   // equals x / 100 for every x below 2^ProdW (error term 68 * x < 2^25).
   localparam int RecipShift = 25;
   localparam int RecipW     = 19;
   localparam logic [RecipW-1:0] RecipPct =
      RecipW'(((1 << RecipShift) + PctDiv - 1) / PctDiv);
   localparam int ScaleW     = ProdW + RecipW;

   // Calibration table
   localparam int TableEntries = 11;
   localparam int IdxW = $clog2(TableEntries);
   localparam logic [AdjW-1:0] CalTable [TableEntries] = '{
      12'd783, 12'd805, 12'd828, 12'd851, 12'd874, 12'd897,
      12'd919, 12'd942, 12'd965, 12'd988, 12'd1011
   };

   // Register map (word index = paddr[2])
   localparam int CsrAddrW = 3;
   localparam logic RegTempShift      = 1'b0;
   localparam logic RegAlarmThreshold = 1'b1;
   localparam logic [ShiftW-1:0] TempShiftReset      = 8'd120;
   localparam logic [AdjW-1:0]   AlarmThresholdReset = 12'd750;

   typedef struct packed {
      logic [ShiftW-1:0] temp_shift;
      logic [AdjW-1:0]   alarm_threshold;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [DivDW-1:0] dividend;
      logic [DivVW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DivDW-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SEARCH,
      ST_FRAC_START,
      ST_FRAC_WAIT,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/tcbac_div.sv
// tcbac_div: restoring divider, one quotient bit per cycle.
// Depends on tcbac_pkg.
module tcbac_div import tcbac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DivDW-1:0]   quo_ff, quo_in;
   logic [DivVW-1:0]   rem_ff, rem_in;
   logic [DivVW-1:0]   dvs_ff, dvs_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [DivVW:0]     trial;
   logic               fits;

   assign trial = {rem_ff, quo_ff[DivDW-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
         cnt_in = DivCntW'(DivDW);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? DivVW'(trial - {1'b0, dvs_ff}) : DivVW'(trial);
         quo_in = {quo_ff[DivDW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DivCntW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("divider done without a running division");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> run_ff)
      else $error("divider did not start");

endmodule

// File: rtl/tcbac_csr.sv
// tcbac_csr: APB-style register block holding temp_shift and alarm_threshold.
// Depends on tcbac_pkg.
module tcbac_csr import tcbac_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output cfg_type             cfg
);

   logic [ShiftW-1:0] temp_shift_ff;
   logic [AdjW-1:0]   alarm_threshold_ff;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_shift_ff      <= TempShiftReset;
         alarm_threshold_ff <= AlarmThresholdReset;
      end else if (wr_en) begin
         unique case (paddr[2])
            RegTempShift:      temp_shift_ff      <= pwdata[ShiftW-1:0];
            RegAlarmThreshold: alarm_threshold_ff <= pwdata[AdjW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         RegTempShift:      prdata = 32'(temp_shift_ff);
         RegAlarmThreshold: prdata = 32'(alarm_threshold_ff);
         default:           prdata = '0;
      endcase
   end

   assign cfg.temp_shift      = temp_shift_ff;
   assign cfg.alarm_threshold = alarm_threshold_ff;

endmodule

// File: rtl/temp_compensated_bac_lookup_core.sv
// Sequence: the accepted word is scaled, then the table is walked; a count
// at or below the first table entry goes straight to the result strobe,
// otherwise the 18-step divider gives the segment fraction first (skipped
// for a flat segment). One word at a time; busy drops in the strobe cycle.
// The table walk takes one entry per cycle. Sync reset idles the sequencer,
// clears the strobe and restores the CSR defaults; no stall.
module temp_compensated_bac_lookup_core import tcbac_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // command channel
   input  logic                start,
   output logic                busy,
   input  logic [GasW-1:0]     req_gas_count,
   input  logic [TempW-1:0]    req_temp_reading,
   // result channel, one-cycle strobe
   output logic                rsp_valid,
   output logic [AdjW-1:0]     rsp_adjusted_count,
   output logic [BacW-1:0]     rsp_bac_value,
   output logic                rsp_alarm,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type state_ff, state_in;

   // datapath registers
   logic [ProdW-1:0] prod_ff;
   logic [AdjW-1:0]  adj_ff;
   logic [IdxW-1:0]  k_ff;
   logic             below_ff;
   logic [DivDW-1:0] frac_ff;
   logic [AdjW-1:0]  rsp_adj_ff;
   logic [BacW-1:0]  rsp_bac_ff;
   logic             rsp_alarm_ff;
   logic             rsp_valid_ff;

   // sequencer outputs
   logic accept;
   logic prod_load;
   logic adj_load;
   logic k_step;
   logic frac_load;
   logic frac_clear;
   logic rsp_load;

   // combinational helpers
   logic [TempW-1:0]   shift_ext;
   logic [ShiftW-1:0]  gain;
   logic [ProdW-1:0]   prod;
   logic [ScaleW-1:0]  scaled;
   logic [AdjW-1:0]    adj_sat;
   logic [AdjW-1:0]    seg_lo;
   logic [AdjW-1:0]    seg_hi;
   logic               search_below;
   logic               search_more;
   logic               seg_flat;
   logic [BacSumW-1:0] bac_sum;
   logic [BacW-1:0]    bac_sat;

   tcbac_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tcbac_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   // percent gain, clamped at zero when temperature exceeds the shift
   assign shift_ext = TempW'(cfg.temp_shift);
   assign gain = (shift_ext > req_temp_reading) ?
                 ShiftW'(shift_ext - req_temp_reading) : '0;
   assign prod = ProdW'(req_gas_count) * ProdW'(gain);

   // product / 100 by reciprocal multiply; the largest product
   // (1023 * 255%) gives 2608, so the result always fits the 12-bit field
   assign scaled  = ScaleW'(prod_ff) * ScaleW'(RecipPct);
   assign adj_sat = scaled[RecipShift +: AdjW];

   // table walk: k points at the upper end of the current segment
   assign seg_lo       = CalTable[k_ff - 1'b1];
   assign seg_hi       = CalTable[k_ff];
   assign search_below = (adj_ff <= CalTable[0]);
   assign search_more  = (({1'b0, k_ff} + 1'b1) < (IdxW + 1)'(TableEntries)) &&
                         (seg_hi < adj_ff);
   assign seg_flat     = (seg_hi <= seg_lo);

   // (k-1)*10 + frac, saturated
   assign bac_sum = BacSumW'(k_ff - 1'b1) * BacSumW'(SegStep) + BacSumW'(frac_ff);
   assign bac_sat = below_ff ? '0 :
                    (bac_sum > BacSumW'(BacMax)) ? BacW'(BacMax) : bac_sum[BacW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (start) state_in = ST_SCALE;
         ST_SCALE:      state_in = ST_SEARCH;
         ST_SEARCH: begin
            priority if (search_below) state_in = ST_FINISH;
            else if (search_more)      state_in = ST_SEARCH;
            else if (seg_flat)         state_in = ST_FINISH;
            else                       state_in = ST_FRAC_START;
         end
         ST_FRAC_START: state_in = ST_FRAC_WAIT;
         ST_FRAC_WAIT:  if (div_rsp.done) state_in = ST_FINISH;
         ST_FINISH:     state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      prod_load        = 1'b0;
      adj_load         = 1'b0;
      k_step           = 1'b0;
      frac_load        = 1'b0;
      frac_clear       = 1'b0;
      rsp_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      unique case (state_ff)
         ST_IDLE:       prod_load = accept;
         ST_SCALE:      adj_load = 1'b1;
         ST_SEARCH: begin
            k_step     = ~search_below & search_more;
            frac_clear = search_below | (~search_more & seg_flat);
         end
         ST_FRAC_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = DivDW'(adj_ff - seg_lo) * DivDW'(SegStep);
            div_req.divisor  = DivVW'(seg_hi - seg_lo);
         end
         ST_FRAC_WAIT:  frac_load = div_rsp.done;
         ST_FINISH:     rsp_load = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_load;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (prod_load) prod_ff <= prod;
      if (adj_load) begin
         adj_ff   <= adj_sat;
         k_ff     <= IdxW'(1);
         below_ff <= 1'b0;
      end else if (k_step) begin
         k_ff <= k_ff + 1'b1;
      end
      if (frac_clear) begin
         frac_ff  <= '0;
         below_ff <= search_below;
      end else if (frac_load) begin
         frac_ff <= div_rsp.quotient;
      end
      if (rsp_load) begin
         rsp_adj_ff   <= adj_ff;
         rsp_bac_ff   <= bac_sat;
         rsp_alarm_ff <= (adj_ff > cfg.alarm_threshold);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_adjusted_count = rsp_adj_ff;
   assign rsp_bac_value      = rsp_bac_ff;
   assign rsp_alarm          = rsp_alarm_ff;

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after accepting a word");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_FRAC_WAIT))
      else $error("divider finished outside the wait state");

   a_below_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_adjusted_count <= CalTable[0]) |-> (rsp_bac_value == '0))
      else $error("nonzero concentration at or below first table entry");

endmodule
